[rtl/tccs_pkg.sv]
`timescale 1ns / 1ps

package tccs_pkg;

   localparam logic [7:0] ATTR_RESET   = 8'h0F;
   localparam logic [7:0] NEWLINE_CODE = 8'h0A;
   localparam logic [7:0] SPACE_CODE   = 8'h20;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } tccs_req_type;

   typedef struct packed {
      logic [4:0]  cursor_row_out;
      logic [6:0]  cursor_col_out;
      logic [15:0] cell_data;
      logic        scrolled;
   } tccs_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUT,
      ST_CLEAR,
      ST_READ_ADDR,
      ST_READ_DATA,
      ST_SCROLL_COPY,
      ST_SCROLL_DRAIN,
      ST_SCROLL_FILL,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic item_load;
      logic put_do;
      logic clear_write;
      logic cursor_home;
      logic read_capture;
      logic copy_read;
      logic fill_write;
      logic cnt_zero;
      logic cnt_inc;
      logic rsp_load;
   } tccs_cmd_type;

   typedef struct packed {
      logic need_scroll;
      logic cnt_copy_end;
      logic cnt_end;
      logic rsp_busy;
   } tccs_sts_type;

endpackage

[rtl/text_console_cursor_scroll.sv]
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   tccs_req_type: cmd, char_code, cell_index
// rsp_      out        rsp_valid/rsp_stall   tccs_rsp_type: cursor, cell_data, scrolled
// csr_      in         csr_write_enable      csr_write_data: text attribute
//
// One command at a time. Clear and put with scroll walk the whole store cell by cell,
// through the single write port of the store.
// Synchronous reset homes the cursor and sets the attribute to 0Fh; the store is
// not swept, so clear it before the first read.
// A new command is taken while a result is held under rsp_stall; it then waits
// in its last step until the output register frees.

module text_console_cursor_scroll #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tccs_pkg::tccs_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tccs_pkg::tccs_rsp_type rsp_payload,
   input  logic                   csr_write_enable,
   input  logic [7:0]             csr_write_data
);

   tccs_pkg::tccs_cmd_type cmd;
   tccs_pkg::tccs_sts_type sts;

   tccs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_payload.cmd),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tccs_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

[rtl/tccs_ram.sv]
`timescale 1ns / 1ps

module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tccs_ctrl.sv]
`timescale 1ns / 1ps

module tccs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_cmd,
   output logic                  req_stall,
   input  tccs_pkg::tccs_sts_type sts,
   output tccs_pkg::tccs_cmd_type cmd
);

   tccs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tccs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != tccs_pkg::ST_IDLE);
      case (state_ff)
         tccs_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.item_load = 1'b1;
               case (req_cmd)
                  tccs_pkg::CMD_PUT:   state_in = tccs_pkg::ST_PUT;
                  tccs_pkg::CMD_CLEAR: begin
                     cmd.cnt_zero = 1'b1;
                     state_in     = tccs_pkg::ST_CLEAR;
                  end
                  tccs_pkg::CMD_READ:  state_in = tccs_pkg::ST_READ_ADDR;
                  default:             state_in = tccs_pkg::ST_RESPOND;
               endcase
            end
         end
         tccs_pkg::ST_PUT: begin
            cmd.put_do = 1'b1;
            if (sts.need_scroll) begin
               cmd.cnt_zero = 1'b1;
               state_in     = tccs_pkg::ST_SCROLL_COPY;
            end else begin
               state_in = tccs_pkg::ST_RESPOND;
            end
         end
         tccs_pkg::ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            cmd.cnt_inc     = 1'b1;
            if (sts.cnt_end) begin
               cmd.cursor_home = 1'b1;
               state_in        = tccs_pkg::ST_RESPOND;
            end
         end
         tccs_pkg::ST_READ_ADDR: state_in = tccs_pkg::ST_READ_DATA;
         tccs_pkg::ST_READ_DATA: begin
            cmd.read_capture = 1'b1;
            state_in         = tccs_pkg::ST_RESPOND;
         end
         tccs_pkg::ST_SCROLL_COPY: begin
            cmd.copy_read = 1'b1;
            cmd.cnt_inc   = 1'b1;
            if (sts.cnt_copy_end) begin
               state_in = tccs_pkg::ST_SCROLL_DRAIN;
            end
         end
         tccs_pkg::ST_SCROLL_DRAIN: state_in = tccs_pkg::ST_SCROLL_FILL;
         tccs_pkg::ST_SCROLL_FILL: begin
            cmd.fill_write = 1'b1;
            cmd.cnt_inc    = 1'b1;
            if (sts.cnt_end) begin
               state_in = tccs_pkg::ST_RESPOND;
            end
         end
         tccs_pkg::ST_RESPOND: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = tccs_pkg::ST_IDLE;
            end
         end
         default: state_in = tccs_pkg::ST_IDLE;
      endcase
   end

endmodule

[rtl/tccs_datapath.sv]
`timescale 1ns / 1ps

module tccs_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tccs_pkg::tccs_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tccs_pkg::tccs_rsp_type rsp_payload,
   input  logic                   csr_write_enable,
   input  logic [7:0]             csr_write_data,
   input  tccs_pkg::tccs_cmd_type cmd,
   output tccs_pkg::tccs_sts_type sts
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int RW         = $clog2(ROWS);
   localparam int CW         = $clog2(COLUMNS);

   tccs_pkg::tccs_req_type item_ff;
   tccs_pkg::tccs_rsp_type rsp_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             attr_ff;
   logic [RW-1:0]          row_ff, row_in;
   logic [CW-1:0]          col_ff, col_in;
   logic [AW-1:0]          base_ff, base_in;
   logic [AW-1:0]          cnt_ff;
   logic                   pend_ff;
   logic [AW-1:0]          dst_ff;
   logic                   scrolled_ff;
   logic [15:0]            data_ff;

   logic                   is_newline;
   logic                   wrap;
   logic                   idx_in_range;
   logic [15:0]            blank;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [15:0]            wr_data;
   logic [AW-1:0]          rd_addr;
   logic [15:0]            rd_data;

   assign is_newline   = (item_ff.char_code == tccs_pkg::NEWLINE_CODE);
   assign wrap         = is_newline || (col_ff == CW'(COLUMNS - 1));
   assign idx_in_range = (32'(item_ff.cell_index) < 32'(CELL_COUNT));
   assign blank        = {attr_ff, tccs_pkg::SPACE_CODE};

   assign sts.need_scroll  = wrap && (row_ff == RW'(ROWS - 1));
   assign sts.cnt_copy_end = (cnt_ff == AW'(CELL_COUNT - COLUMNS - 1));
   assign sts.cnt_end      = (cnt_ff == AW'(CELL_COUNT - 1));
   assign sts.rsp_busy     = rsp_valid_ff && rsp_stall;

   // cursor update for a put, or homing at the end of a clear; the scroll itself only moves the store
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      base_in = base_ff;
      if (cmd.cursor_home) begin
         row_in  = '0;
         col_in  = '0;
         base_in = '0;
      end else if (cmd.put_do) begin
         if (wrap) begin
            col_in = '0;
            if (row_ff != RW'(ROWS - 1)) begin
               row_in  = row_ff + RW'(1);
               base_in = base_ff + AW'(COLUMNS);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // store write port: pending copy beats everything else
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = blank;
      if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = dst_ff;
         wr_data = rd_data;
      end else if (cmd.put_do && !is_newline) begin
         wr_en   = 1'b1;
         wr_addr = base_ff + AW'(col_ff);
         wr_data = {attr_ff, item_ff.char_code};
      end else if (cmd.clear_write || cmd.fill_write) begin
         wr_en = 1'b1;
      end
   end

   assign rd_addr = cmd.copy_read ? (cnt_ff + AW'(COLUMNS)) : AW'(item_ff.cell_index);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         attr_ff      <= tccs_pkg::ATTR_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         pend_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         pend_ff      <= cmd.copy_read;
         if (csr_write_enable) begin
            attr_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      dst_ff <= cnt_ff;
      if (cmd.cnt_zero) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + AW'(1);
      end
      if (cmd.item_load) begin
         item_ff     <= req_payload;
         scrolled_ff <= 1'b0;
         data_ff     <= '0;
      end else begin
         if (cmd.put_do) begin
            scrolled_ff <= sts.need_scroll;
         end
         if (cmd.read_capture) begin
            data_ff <= idx_in_range ? rd_data : 16'h0000;
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.cursor_row_out <= 5'(row_ff);
         rsp_ff.cursor_col_out <= 7'(col_ff);
         rsp_ff.cell_data      <= data_ff;
         rsp_ff.scrolled       <= scrolled_ff;
      end
   end

   tccs_ram #(
      .WIDTH (16),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[sim/tb_text_console_cursor_scroll.sv]
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll;
   import tccs_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic         clock;
   logic         reset            = 1'b1;
   logic         req_valid        = 1'b0;
   logic         req_stall;
   tccs_req_type req_payload      = '0;
   logic         rsp_valid;
   logic         rsp_stall        = 1'b0;
   tccs_rsp_type rsp_payload;
   logic         csr_write_enable = 1'b0;
   logic [7:0]   csr_write_data   = '0;

   text_console_cursor_scroll #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   // shadow console
   logic [15:0]  screen [CELLS];
   int           cur_row;
   int           cur_col;
   logic [7:0]   text_attr = ATTR_RESET;

   tccs_req_type pending_cmds [$];
   tccs_rsp_type expected_rsp [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches    = 0;
   int checked       = 0;
   int n_puts        = 0;
   int n_clears      = 0;
   int n_reads       = 0;
   int n_scrolls     = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic tccs_rsp_type console_apply(tccs_req_type item);
      tccs_rsp_type r;
      logic [15:0]  blank;
      int           pos;
      int           i;
      r     = '0;
      blank = {text_attr, SPACE_CODE};
      case (item.cmd)
         CMD_PUT: begin
            if (item.char_code == NEWLINE_CODE) begin
               cur_col = 0;
               cur_row++;
            end else begin
               pos = cur_row * COLUMNS + cur_col;
               if (pos < CELLS)
                  screen[pos] = {text_attr, item.char_code};
               cur_col++;
            end
            if (cur_col >= COLUMNS) begin
               cur_col = 0;
               cur_row++;
            end
            if (cur_row >= ROWS) begin
               for (i = 0; i < CELLS - COLUMNS; i++)
                  screen[i] = screen[i + COLUMNS];
               for (i = CELLS - COLUMNS; i < CELLS; i++)
                  screen[i] = blank;
               cur_row    = ROWS - 1;
               r.scrolled = 1'b1;
            end
         end
         CMD_CLEAR: begin
            for (i = 0; i < CELLS; i++)
               screen[i] = blank;
            cur_row = 0;
            cur_col = 0;
         end
         CMD_READ: begin
            if (item.cell_index < CELLS)
               r.cell_data = screen[item.cell_index];
         end
         default: ;
      endcase
      r.cursor_row_out = cur_row[4:0];
      r.cursor_col_out = cur_col[6:0];
      return r;
   endfunction

   function automatic tccs_req_type make_cmd(logic [1:0] cmd, logic [7:0] ch, logic [10:0] idx);
      tccs_req_type t;
      t.cmd        = cmd;
      t.char_code  = ch;
      t.cell_index = idx;
      return t;
   endfunction

   function automatic logic [10:0] pick_cell();
      int p;
      p = $urandom_range(9);
      if (p < 4)
         return 11'($urandom_range(CELLS - 1));
      else if (p < 7)
         return 11'($urandom_range(CELLS - 1, CELLS - 6 * COLUMNS));
      else if (p < 9)
         return 11'($urandom_range(3 * COLUMNS - 1));
      return 11'($urandom_range(2047, CELLS));
   endfunction

   function automatic logic [7:0] pick_char();
      if ($urandom_range(9) == 0)
         return 8'($urandom);
      return 8'($urandom_range(126, 32));
   endfunction

   task automatic queue_random_traffic(int n);
      int queued;
      int pick;
      int len;
      int k;
      queued = 0;
      while (queued < n) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            len = $urandom_range(30, 1);
            for (k = 0; k < len; k++)
               pending_cmds.push_back(make_cmd(CMD_PUT, pick_char(), 11'($urandom)));
         end else if (pick < 47) begin
            len = $urandom_range(90, 60);
            for (k = 0; k < len; k++)
               pending_cmds.push_back(make_cmd(CMD_PUT, pick_char(), 11'($urandom)));
         end else if (pick < 62) begin
            len = $urandom_range(6, 1);
            for (k = 0; k < len; k++)
               pending_cmds.push_back(make_cmd(CMD_PUT, NEWLINE_CODE, 11'($urandom)));
         end else if (pick < 82) begin
            len = $urandom_range(4, 1);
            for (k = 0; k < len; k++)
               pending_cmds.push_back(make_cmd(CMD_READ, 8'($urandom), pick_cell()));
         end else if (pick < 85) begin
            len = 1;
            pending_cmds.push_back(make_cmd(CMD_CLEAR, 8'($urandom), 11'($urandom)));
         end else if (pick < 88) begin
            len = 1;
            pending_cmds.push_back(make_cmd(CMD_UNUSED, 8'($urandom), 11'($urandom)));
         end else begin
            len = 1;
            pending_cmds.push_back(make_cmd(2'($urandom), 8'($urandom), 11'($urandom)));
         end
         queued += len;
      end
   endtask

   // wait until the block is quiet, then let the clock run idle before touching the register
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_rsp.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_attribute(logic [7:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      text_attr = value;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(console_apply(req_payload));
            case (req_payload.cmd)
               CMD_PUT:   n_puts++;
               CMD_CLEAR: n_clears++;
               CMD_READ:  n_reads++;
               default: ;
            endcase
         end
         if (!req_valid || !req_stall) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= pending_cmds.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      tccs_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected transfer row %0d col %0d data %04h scrolled %0b",
                           rsp_payload.cursor_row_out, rsp_payload.cursor_col_out,
                           rsp_payload.cell_data, rsp_payload.scrolled);
            end else begin
               want = expected_rsp.pop_front();
               if (want.scrolled) n_scrolls++;
               if (rsp_payload.cursor_row_out !== want.cursor_row_out ||
                   rsp_payload.cursor_col_out !== want.cursor_col_out ||
                   rsp_payload.cell_data !== want.cell_data ||
                   rsp_payload.scrolled !== want.scrolled) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: transfer %0d exp row %0d col %0d data %04h scr %0b,",
                              checked, want.cursor_row_out, want.cursor_col_out,
                              want.cell_data, want.scrolled,
                              " got row %0d col %0d data %04h scr %0b",
                              rsp_payload.cursor_row_out, rsp_payload.cursor_col_out,
                              rsp_payload.cell_data, rsp_payload.scrolled);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin
      logic [7:0] last_attr;
      int         k;
      cur_row = 0;
      cur_col = 0;
      for (k = 0; k < CELLS; k++)
         screen[k] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: clear first so no unwritten cell is ever read
      send_idle_pct = 26;
      recv_idle_pct = 87;
      pending_cmds.push_back(make_cmd(CMD_CLEAR, 8'h00, 11'h000));
      pending_cmds.push_back(make_cmd(CMD_PUT, 8'h00, 11'h7FF));
      pending_cmds.push_back(make_cmd(CMD_PUT, 8'hFF, 11'h000));
      pending_cmds.push_back(make_cmd(CMD_READ, 8'hFF, 11'd0));
      pending_cmds.push_back(make_cmd(CMD_READ, 8'h00, 11'd1));
      pending_cmds.push_back(make_cmd(CMD_READ, 8'h00, 11'(CELLS - 1)));
      pending_cmds.push_back(make_cmd(CMD_READ, 8'h00, 11'(CELLS)));
      pending_cmds.push_back(make_cmd(CMD_READ, 8'h00, 11'h7FF));
      pending_cmds.push_back(make_cmd(CMD_UNUSED, 8'hFF, 11'h7FF));
      // walk to the bottom row, then one more newline to force a scroll
      for (k = 0; k < ROWS; k++)
         pending_cmds.push_back(make_cmd(CMD_PUT, NEWLINE_CODE, 11'($urandom)));
      queue_random_traffic(330);
      wait_drained();

      write_attribute(8'h00);
      send_idle_pct = 87;
      recv_idle_pct = 26;
      queue_random_traffic(330);
      wait_drained();

      write_attribute(8'hFF);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_traffic(170);
      wait_drained();

      last_attr = 8'($urandom);
      write_attribute(last_attr);
      queue_random_traffic(170);
      wait_drained();
      repeat (20) @(posedge clock);

      $display("Checked %0d transfers: %0d puts, %0d clears, %0d reads, %0d scrolls",
               checked, n_puts, n_clears, n_reads, n_scrolls);
      $display("Attributes 0f, 00, ff and %02h under three idle patterns; %0d mismatches",
               last_attr, mismatches);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // each scroll or clear walks the store once; allow for every command doing so under heavy stall
   initial begin
      #80_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/tccs_pkg.sv
rtl/tccs_ram.sv
rtl/tccs_ctrl.sv
rtl/tccs_datapath.sv
rtl/text_console_cursor_scroll.sv
sim/tb_text_console_cursor_scroll.sv
